>>> rtl/npsjf_pkg.sv
// Shared constants and controller/datapath interface types for the SJF scheduler.
package npsjf_pkg;

  localparam int MaxJobs = 16;
  localparam int SlotW   = $clog2(MaxJobs);
  localparam int CntW    = SlotW + 1;
  localparam int TimeW   = 16;

  localparam logic [TimeW-1:0] TimeMax = {TimeW{1'b1}};

  localparam logic ReqLoad = 1'b0;
  localparam logic ReqTick = 1'b1;

  typedef struct packed {
    logic accept;
    logic load_wr;
    logic tick_chk;
    logic scan_step;
    logic take_pick;
    logic run_rd;
    logic run_wr;
    logic idle_adv;
  } dp_cmd_t;

  typedef struct packed {
    logic eff_busy;
    logic scan_end;
    logic found;
  } dp_stat_t;

endpackage

>>> rtl/npsjf_ctrl.sv
// Controller state machine: sequences load, scan, and run steps of one transaction.
module npsjf_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  input  logic                req_type_i,
  input  npsjf_pkg::dp_stat_t stat_i,
  output npsjf_pkg::dp_cmd_t  cmd_o,
  output logic                busy,
  output logic                result_valid_o
);

  localparam logic [2:0] StIdle    = 3'd0;
  localparam logic [2:0] StLoad    = 3'd1;
  localparam logic [2:0] StChk     = 3'd2;
  localparam logic [2:0] StScan    = 3'd3;
  localparam logic [2:0] StScanEnd = 3'd4;
  localparam logic [2:0] StRunRd   = 3'd5;
  localparam logic [2:0] StRunWr   = 3'd6;

  logic [2:0] state_q, state_d;
  logic       strobe_q, strobe_d;

  always_comb begin
    state_d  = state_q;
    strobe_d = 1'b0;
    cmd_o    = '0;
    unique case (state_q)
      StIdle: begin
        if (start) begin
          cmd_o.accept = 1'b1;
          state_d = (req_type_i == npsjf_pkg::ReqTick) ? StChk : StLoad;
        end
      end
      StLoad: begin
        cmd_o.load_wr = 1'b1;
        strobe_d      = 1'b1;
        state_d       = StIdle;
      end
      StChk: begin
        cmd_o.tick_chk = 1'b1;
        state_d = stat_i.eff_busy ? StRunRd : StScan;
      end
      StScan: begin
        cmd_o.scan_step = 1'b1;
        if (stat_i.scan_end) state_d = StScanEnd;
      end
      StScanEnd: begin
        if (stat_i.found) begin
          cmd_o.take_pick = 1'b1;
          state_d         = StRunRd;
        end else begin
          cmd_o.idle_adv = 1'b1;
          strobe_d       = 1'b1;
          state_d        = StIdle;
        end
      end
      StRunRd: begin
        cmd_o.run_rd = 1'b1;
        state_d      = StRunWr;
      end
      StRunWr: begin
        cmd_o.run_wr = 1'b1;
        strobe_d     = 1'b1;
        state_d      = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      strobe_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      strobe_q <= strobe_d;
    end
  end

  assign busy           = (state_q != StIdle);
  assign result_valid_o = strobe_q;

`ifndef ASSERT_OFF
  a_strobe_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_q |-> $past(state_q) != StIdle)
    else $error("result strobe without a transaction in progress");

  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StIdle && start) |=> state_q != StIdle)
    else $error("accepted transaction did not leave idle");
`endif

endmodule

>>> rtl/npsjf_datapath.sv
// Datapath: job tables, minimum search, run counter, time and result registers.
module npsjf_datapath (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  npsjf_pkg::dp_cmd_t                   cmd_i,
  output npsjf_pkg::dp_stat_t                  stat_o,
  input  logic                                 job_count_we_i,
  input  logic [npsjf_pkg::CntW-1:0]           job_count_i,
  input  logic [npsjf_pkg::SlotW-1:0]          job_slot_i,
  input  logic [npsjf_pkg::TimeW-1:0]          arrival_time_i,
  input  logic [15:0]                          run_length_i,
  output logic [npsjf_pkg::SlotW-1:0]          running_job_o,
  output logic                                 running_valid_o,
  output logic                                 job_done_o,
  output logic                                 all_done_o,
  output logic [npsjf_pkg::TimeW-1:0]          now_time_o
);

  localparam int SW = npsjf_pkg::SlotW;
  localparam int CW = npsjf_pkg::CntW;
  localparam int TW = npsjf_pkg::TimeW;
  localparam int NJ = npsjf_pkg::MaxJobs;

  logic [TW-1:0] arr_mem [NJ];
  logic [15:0]   rem_mem [NJ];
  logic [TW-1:0] arr_rd_q;
  logic [15:0]   rem_rd_q;

  logic [SW-1:0] slot_q;
  logic [TW-1:0] arr_q;
  logic [15:0]   len_q;

  logic [NJ-1:0] nz_q, nz_d;
  logic [CW-1:0] count_q;
  logic [CW-1:0] used;
  logic [CW-1:0] idx_q, idx_d;
  logic          p_vld_q, p_vld_d;
  logic [SW-1:0] p_idx_q;
  logic [SW-1:0] best_q, best_d;
  logic [15:0]   best_len_q, best_len_d;
  logic          found_q, found_d;
  logic [SW-1:0] cur_q, cur_d;
  logic          busy_q, busy_d;
  logic [TW-1:0] clock_q, clock_d;
  logic [SW-1:0] res_job_q, res_job_d;
  logic          res_ran_q, res_ran_d;
  logic          res_done_q, res_done_d;

  logic [SW-1:0] rd_addr;
  logic          elig, better, pending;
  logic [15:0]   rem_new;
  logic [TW-1:0] clock_inc;

  assign used    = (count_q > CW'(NJ)) ? CW'(NJ) : count_q;
  assign rd_addr = cmd_i.run_rd ? cur_q : idx_q[SW-1:0];
  assign rem_new = rem_rd_q - 16'd1;
  assign clock_inc = (clock_q != npsjf_pkg::TimeMax) ? clock_q + 1'b1 : clock_q;

  assign elig   = p_vld_q && nz_q[p_idx_q] && (arr_rd_q <= clock_q);
  assign better = elig && (!found_q || rem_rd_q < best_len_q);

  always_comb begin
    pending = 1'b0;
    for (int i = 0; i < NJ; i++) begin
      if (CW'(i) < used && nz_q[i]) pending = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_wr) begin
      arr_mem[slot_q] <= arr_q;
      rem_mem[slot_q] <= len_q;
    end else if (cmd_i.run_wr) begin
      rem_mem[cur_q] <= rem_new;
    end
    arr_rd_q <= arr_mem[rd_addr];
    rem_rd_q <= rem_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      slot_q <= job_slot_i;
      arr_q  <= arrival_time_i;
      len_q  <= run_length_i;
    end
    p_idx_q <= idx_q[SW-1:0];
  end

  always_comb begin
    nz_d       = nz_q;
    idx_d      = idx_q;
    p_vld_d    = 1'b0;
    best_d     = best_q;
    best_len_d = best_len_q;
    found_d    = found_q;
    cur_d      = cur_q;
    busy_d     = busy_q;
    clock_d    = clock_q;
    res_job_d  = res_job_q;
    res_ran_d  = res_ran_q;
    res_done_d = res_done_q;

    if (cmd_i.accept) begin
      res_job_d  = '0;
      res_ran_d  = 1'b0;
      res_done_d = 1'b0;
    end
    if (cmd_i.load_wr) begin
      nz_d[slot_q] = (len_q != 16'd0);
    end
    if (cmd_i.tick_chk) begin
      busy_d  = busy_q && nz_q[cur_q];
      idx_d   = '0;
      found_d = 1'b0;
    end
    if (cmd_i.scan_step && idx_q < used) begin
      p_vld_d = 1'b1;
      idx_d   = idx_q + 1'b1;
    end
    if (better) begin
      found_d    = 1'b1;
      best_d     = p_idx_q;
      best_len_d = rem_rd_q;
    end
    if (cmd_i.take_pick) begin
      busy_d = 1'b1;
      cur_d  = best_q;
    end
    if (cmd_i.run_wr) begin
      nz_d[cur_q] = (rem_new != 16'd0);
      busy_d      = (rem_new != 16'd0);
      res_job_d   = cur_q;
      res_ran_d   = 1'b1;
      res_done_d  = (rem_new == 16'd0);
      clock_d     = clock_inc;
    end
    if (cmd_i.idle_adv && pending) begin
      clock_d = clock_inc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nz_q       <= '0;
      count_q    <= '0;
      idx_q      <= '0;
      p_vld_q    <= 1'b0;
      best_q     <= '0;
      best_len_q <= '0;
      found_q    <= 1'b0;
      cur_q      <= '0;
      busy_q     <= 1'b0;
      clock_q    <= '0;
      res_job_q  <= '0;
      res_ran_q  <= 1'b0;
      res_done_q <= 1'b0;
    end else begin
      nz_q       <= nz_d;
      if (job_count_we_i) count_q <= job_count_i;
      idx_q      <= idx_d;
      p_vld_q    <= p_vld_d;
      best_q     <= best_d;
      best_len_q <= best_len_d;
      found_q    <= found_d;
      cur_q      <= cur_d;
      busy_q     <= busy_d;
      clock_q    <= clock_d;
      res_job_q  <= res_job_d;
      res_ran_q  <= res_ran_d;
      res_done_q <= res_done_d;
    end
  end

  assign stat_o.eff_busy = busy_q && nz_q[cur_q];
  assign stat_o.scan_end = (idx_q >= used);
  assign stat_o.found    = found_q;

  assign running_job_o   = res_job_q;
  assign running_valid_o = res_ran_q;
  assign job_done_o      = res_done_q;
  assign all_done_o      = !pending;
  assign now_time_o      = clock_q;

`ifndef ASSERT_OFF
  a_run_has_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.run_wr |-> nz_q[cur_q] && busy_q)
    else $error("run step on a finished or inactive job");

  a_pick_is_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.take_pick |-> found_q && nz_q[best_q])
    else $error("picked slot has no remaining work");
`endif

endmodule

>>> rtl/nonpreemptive_sjf_scheduler_top.sv
// Top level of the non-preemptive shortest-job-first scheduler.
// Usage:
//   Input transactions are accepted at a rising edge with start high and busy
//   low. req_type_i = 0 loads job_slot_i with arrival_time_i and run_length_i;
//   req_type_i = 1 runs one tick, advancing time (saturating at TimeMax) unless all jobs are done.
//   Every transaction yields one result, shown for exactly one cycle with
//   result_valid_o high. The receiver cannot stall; results are never held.
//   job_count_we_i writes job_count_i (slots in use); the user must write it
//   only while the block is idle, which the block itself does not enforce.
// Steps: a load writes the slot. A tick with a job already running reads and
//   decrements its remaining length. Otherwise the tick scans the used slots
//   (job_count capped at 16), one slot per cycle through the job table read
//   port, then runs the shortest eligible job or, with none eligible, advances
//   time while jobs remain. busy is low in the strobe cycle, so the next
//   transaction may be accepted at the edge that ends it.
// Reset: asynchronous, active low; clears time, job_count, the running job
//   and every job's pending flag. Arrival times and remaining lengths are unknown until loaded.
module nonpreemptive_sjf_scheduler_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic                          job_count_we_i,
  input  logic [npsjf_pkg::CntW-1:0]    job_count_i,
  input  logic                          req_type_i,
  input  logic [npsjf_pkg::SlotW-1:0]   job_slot_i,
  input  logic [npsjf_pkg::TimeW-1:0]   arrival_time_i,
  input  logic [15:0]                   run_length_i,
  output logic                          result_valid_o,
  output logic [npsjf_pkg::SlotW-1:0]   running_job_o,
  output logic                          running_valid_o,
  output logic                          job_done_o,
  output logic                          all_done_o,
  output logic [npsjf_pkg::TimeW-1:0]   now_time_o
);

  npsjf_pkg::dp_cmd_t  cmd;
  npsjf_pkg::dp_stat_t stat;

  npsjf_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .req_type_i     (req_type_i),
    .stat_i         (stat),
    .cmd_o          (cmd),
    .busy           (busy),
    .result_valid_o (result_valid_o)
  );

  npsjf_datapath u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .job_count_we_i  (job_count_we_i),
    .job_count_i     (job_count_i),
    .job_slot_i      (job_slot_i),
    .arrival_time_i  (arrival_time_i),
    .run_length_i    (run_length_i),
    .running_job_o   (running_job_o),
    .running_valid_o (running_valid_o),
    .job_done_o      (job_done_o),
    .all_done_o      (all_done_o),
    .now_time_o      (now_time_o)
  );

endmodule

>>> bench/nonpreemptive_sjf_scheduler_top_tb.sv
// Self-checking bench for the SJF scheduler: directed and random runs.
`timescale 1ns / 100ps

module nonpreemptive_sjf_scheduler_top_tb;

  localparam int MaxJobs = npsjf_pkg::MaxJobs;
  localparam int SlotW   = npsjf_pkg::SlotW;
  localparam int CntW    = npsjf_pkg::CntW;
  localparam int TimeW   = npsjf_pkg::TimeW;

  typedef struct packed {
    logic [SlotW-1:0] job;
    logic             ran;
    logic             done;
    logic             all_fin;
    logic [TimeW-1:0] now;
  } sched_out_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             start = 1'b0;
  logic             busy;
  logic             job_count_we_i = 1'b0;
  logic [CntW-1:0]  job_count_i = '0;
  logic             req_type_i = npsjf_pkg::ReqLoad;
  logic [SlotW-1:0] job_slot_i = '0;
  logic [TimeW-1:0] arrival_time_i = '0;
  logic [15:0]      run_length_i = '0;
  logic             result_valid_o;
  logic [SlotW-1:0] running_job_o;
  logic             running_valid_o;
  logic             job_done_o;
  logic             all_done_o;
  logic [TimeW-1:0] now_time_o;

  // scheduler shadow state
  logic [TimeW-1:0] arrival_tbl [MaxJobs];
  logic [15:0]      remain_tbl [MaxJobs];
  logic [SlotW-1:0] cur_slot;
  logic             running;
  logic [TimeW-1:0] clk_now;
  logic [CntW-1:0]  job_cnt;

  sched_out_t sched_results_due [$];
  int items_sent = 0;
  int results_seen = 0;
  int mismatches = 0;
  int gap_pct = 0;

  nonpreemptive_sjf_scheduler_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .job_count_we_i (job_count_we_i),
    .job_count_i    (job_count_i),
    .req_type_i     (req_type_i),
    .job_slot_i     (job_slot_i),
    .arrival_time_i (arrival_time_i),
    .run_length_i   (run_length_i),
    .result_valid_o (result_valid_o),
    .running_job_o  (running_job_o),
    .running_valid_o(running_valid_o),
    .job_done_o     (job_done_o),
    .all_done_o     (all_done_o),
    .now_time_o     (now_time_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  initial begin
    #20_000_000;
    $display("[nonpreemptive_sjf_scheduler_top] ERROR");
    $finish;
  end

  function automatic logic table_finished();
    int lim;
    lim = (job_cnt > MaxJobs) ? MaxJobs : int'(job_cnt);
    for (int i = 0; i < lim; i++)
      if (remain_tbl[i[SlotW-1:0]] != 0) return 1'b0;
    return 1'b1;
  endfunction

  function automatic sched_out_t next_schedule_result(logic rt, logic [SlotW-1:0] slot,
                                                      logic [TimeW-1:0] arr,
                                                      logic [15:0] len);
    sched_out_t r;
    int lim;
    int pick;
    r = '0;
    lim = (job_cnt > MaxJobs) ? MaxJobs : int'(job_cnt);
    if (rt == npsjf_pkg::ReqLoad) begin
      arrival_tbl[slot] = arr;
      remain_tbl[slot]  = len;
    end else begin
      if (running && remain_tbl[cur_slot] == 0) running = 1'b0;
      if (!running) begin
        pick = -1;
        for (int i = 0; i < lim; i++)
          if (remain_tbl[i[SlotW-1:0]] != 0 && arrival_tbl[i[SlotW-1:0]] <= clk_now &&
              (pick < 0 || remain_tbl[i[SlotW-1:0]] < remain_tbl[pick[SlotW-1:0]]))
            pick = i;
        if (pick >= 0) begin
          running  = 1'b1;
          cur_slot = pick[SlotW-1:0];
        end
      end
      if (running) begin
        r.job = cur_slot;
        r.ran = 1'b1;
        remain_tbl[cur_slot] = remain_tbl[cur_slot] - 16'd1;
        if (clk_now != npsjf_pkg::TimeMax) clk_now = clk_now + 1'b1;
        if (remain_tbl[cur_slot] == 0) begin
          r.done  = 1'b1;
          running = 1'b0;
        end
      end else if (!table_finished()) begin
        if (clk_now != npsjf_pkg::TimeMax) clk_now = clk_now + 1'b1;
      end
    end
    r.all_fin = table_finished();
    r.now     = clk_now;
    return r;
  endfunction

  function automatic string fmt_result(sched_out_t r);
    return $sformatf("job=%0d ran=%b done=%b all_done=%b now=%0d",
                     r.job, r.ran, r.done, r.all_fin, r.now);
  endfunction

  function automatic logic [15:0] rand_length();
    int r;
    r = $urandom_range(99);
    if (r < 15) return '0;
    if (r < 80) return 16'($urandom_range(1, 6));
    if (r < 95) return 16'($urandom_range(7, 40));
    return 16'($urandom);
  endfunction

  function automatic logic [TimeW-1:0] rand_arrival();
    int r;
    r = $urandom_range(99);
    if (r < 10) return TimeW'($urandom);
    if (r < 25) return clk_now - TimeW'($urandom_range(0, 3));
    return clk_now + TimeW'($urandom_range(0, 6));
  endfunction

  always @(posedge clk_i) begin : sched_check
    sched_out_t got;
    sched_out_t want;
    if (rst_ni && result_valid_o === 1'b1) begin
      got = {running_job_o, running_valid_o, job_done_o, all_done_o, now_time_o};
      results_seen++;
      if (sched_results_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected transaction result: %s", $time, fmt_result(got));
      end else begin
        want = sched_results_due.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: result %0d mismatch\n  exp %s\n  got %s", $time, results_seen,
                     fmt_result(want), fmt_result(got));
        end
      end
    end
  end

  task automatic send_item(logic rt, logic [SlotW-1:0] slot, logic [TimeW-1:0] arr,
                           logic [15:0] len);
    while ($urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start          <= 1'b1;
    req_type_i     <= rt;
    job_slot_i     <= slot;
    arrival_time_i <= arr;
    run_length_i   <= len;
    do @(posedge clk_i); while (busy !== 1'b0);
    sched_results_due.push_back(next_schedule_result(rt, slot, arr, len));
    items_sent++;
  endtask

  task automatic send_tick();
    send_item(npsjf_pkg::ReqTick, SlotW'($urandom), TimeW'($urandom), 16'($urandom));
  endtask

  task automatic wait_results_drained();
    start <= 1'b0;
    while (sched_results_due.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_count(logic [CntW-1:0] v);
    wait_results_drained();
    job_count_we_i <= 1'b1;
    job_count_i    <= v;
    @(posedge clk_i);
    job_count_we_i <= 1'b0;
    job_cnt = v;
  endtask

  // job_count is zero after reset: nothing to run, time must hold
  task automatic test_empty_table();
    repeat (2) send_tick();
  endtask

  // ties, late shorter arrival, zero lengths, reloads of the running job
  task automatic test_fill_table();
    logic [TimeW-1:0] arr;
    logic [15:0]      len;
    write_count(5'd31);
    for (int s = 0; s < MaxJobs; s++) begin
      arr = (s == 15) ? npsjf_pkg::TimeMax : (s == 10) ? 16'd1 : 16'd0;
      len = (s == 15) ? 16'hFFFF : (s == 3 || s == 7) ? 16'd2 : (s == 10) ? 16'd1 : 16'd0;
      send_item(npsjf_pkg::ReqLoad, s[SlotW-1:0], arr, len);
    end
    repeat (4) send_tick();
    send_item(npsjf_pkg::ReqLoad, 4'd7, '0, 16'd3);
    send_tick();
    send_item(npsjf_pkg::ReqLoad, 4'd7, '0, '0);
    send_tick();
    send_item(npsjf_pkg::ReqLoad, 4'd15, npsjf_pkg::TimeMax, '0);
    write_count(5'd16);
    send_tick();
  endtask

  task automatic test_random(int pct, int n);
    int stop_at;
    int cnt;
    int ticks;
    gap_pct = pct;
    stop_at = items_sent + n;
    while (items_sent < stop_at) begin
      if ($urandom_range(3) == 0)
        write_count(CntW'(($urandom_range(9) < 7) ? $urandom_range(1, 6)
                                                  : $urandom_range(0, 31)));
      cnt = (job_cnt > MaxJobs) ? MaxJobs : int'(job_cnt);
      if (running && remain_tbl[cur_slot] > 20)
        send_item(npsjf_pkg::ReqLoad, cur_slot, clk_now, 16'($urandom_range(1, 4)));
      for (int s = 0; s < cnt; s++)
        send_item(npsjf_pkg::ReqLoad, s[SlotW-1:0], rand_arrival(), rand_length());
      ticks = $urandom_range(4, 40);
      for (int k = 0; k < ticks; k++) begin
        if (!running && table_finished() && $urandom_range(3) == 0) break;
        if ($urandom_range(99) < 12)
          send_item(npsjf_pkg::ReqLoad,
                    (running && $urandom_range(1) != 0) ? cur_slot
                                                       : SlotW'($urandom_range(15)),
                    rand_arrival(), rand_length());
        else
          send_tick();
      end
      if ($urandom_range(7) == 0) wait_results_drained();
    end
  endtask

  initial begin
    foreach (remain_tbl[i]) begin
      remain_tbl[i]  = '0;
      arrival_tbl[i] = '0;
    end
    running  = 1'b0;
    cur_slot = '0;
    clk_now  = '0;
    job_cnt  = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_table();
    test_fill_table();
    test_random(8, 600);
    test_random(76, 600);
    test_random(0, 600);
    wait_results_drained();
    repeat (40) @(posedge clk_i);
    $display("Ran %0d transactions, %0d results checked, %0d mismatching.",
             items_sent, results_seen, mismatches);
    $display("Covered job counts 0 to 31, sender gaps of 0, 8 and 76 percent, ties, %s",
             "zero-length jobs and reloads of the running job.");
    if (mismatches == 0)
      $display("[nonpreemptive_sjf_scheduler_top] OK");
    else
      $display("[nonpreemptive_sjf_scheduler_top] ERROR");
    $finish;
  end

endmodule

>>> sim.f
rtl/npsjf_pkg.sv
rtl/npsjf_ctrl.sv
rtl/npsjf_datapath.sv
rtl/nonpreemptive_sjf_scheduler_top.sv
bench/nonpreemptive_sjf_scheduler_top_tb.sv
